// ===== rtl/lcs_pkg.sv =====
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared constants, types and the brightness-to-hold-time table for the
// LED cube layer scanner.
// ---------------------------------------------------------------------------
package lcs_pkg;

  localparam int LAYERS      = 4;
  localparam int ROW_LEDS    = 4;
  localparam int ROWS        = 4;
  localparam int HOLD_MAX_US = 2500;
  localparam int HOLD_MIN_US = 500;
  localparam int LEVEL_MIN   = 10;
  localparam int LEVEL_MAX   = 255;

  localparam int OP_W    = 3;
  localparam int COORD_W = 2;
  localparam int WORD_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int COUNT_W = 12;
  localparam int DRIVE_W = 4;
  localparam int POS_W   = 5;
  localparam int SCAN_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int LEVELS  = 2 ** LEVEL_W;

  typedef logic [COUNT_W-1:0] lcs_hold_t;
  typedef lcs_hold_t lcs_hold_tab_t [LEVELS];

  localparam lcs_hold_t COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TOGGLE = 3'd3,
    OP_WRITE  = 3'd4,
    OP_FILL   = 3'd5,
    OP_WIPE   = 3'd6,
    OP_READ   = 3'd7
  } lcs_op_t;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } lcs_state_t;

  typedef struct packed {
    logic load_item;
    logic write_cfg;
  } lcs_cmd_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] layer_drive;
    logic [WORD_W-1:0]  column_word;
    logic               layer_switched;
    logic               scan_complete;
    logic               voxel_bit;
    logic [WORD_W-1:0]  layer_word;
  } lcs_result_t;

  // hold time for every raw register value, clamping folded in
  function automatic lcs_hold_tab_t build_hold_table();
    lcs_hold_tab_t tab;
    int            lvl;
    for (int i = 0; i < LEVELS; i++) begin
      lvl = (i < LEVEL_MIN) ? LEVEL_MIN : ((i > LEVEL_MAX) ? LEVEL_MAX : i);
      if (LEVEL_MAX <= LEVEL_MIN) begin
        tab[i] = COUNT_W'(HOLD_MAX_US);
      end else begin
        tab[i] = COUNT_W'(HOLD_MIN_US + (lvl - LEVEL_MIN) * (HOLD_MAX_US - HOLD_MIN_US)
                          / (LEVEL_MAX - LEVEL_MIN));
      end
    end
    return tab;
  endfunction

  localparam lcs_hold_tab_t HOLD_TABLE = build_hold_table();
  localparam lcs_hold_t     HOLD_RESET = HOLD_TABLE[LEVEL_MAX];

endpackage

// ===== rtl/lcs_if.sv =====
// ---------------------------------------------------------------------------
// lcs_if
// Valid/ready channel interfaces for items, results and the brightness
// register write.
// ---------------------------------------------------------------------------
interface lcs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcs_pkg::OP_W-1:0]    op;
  logic [lcs_pkg::COORD_W-1:0] x_pos;
  logic [lcs_pkg::COORD_W-1:0] y_pos;
  logic [lcs_pkg::COORD_W-1:0] layer_sel;
  logic [lcs_pkg::WORD_W-1:0]  pattern;

  modport source (output valid, op, x_pos, y_pos, layer_sel, pattern, input ready);
  modport sink (input valid, op, x_pos, y_pos, layer_sel, pattern, output ready);
endinterface

interface lcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcs_pkg::DRIVE_W-1:0] layer_drive;
  logic [lcs_pkg::WORD_W-1:0]  column_word;
  logic                        layer_switched;
  logic                        scan_complete;
  logic                        voxel_bit;
  logic [lcs_pkg::WORD_W-1:0]  layer_word;

  modport source (output valid, layer_drive, column_word, layer_switched, scan_complete,
                  voxel_bit, layer_word, input ready);
  modport sink (input valid, layer_drive, column_word, layer_switched, scan_complete,
                voxel_bit, layer_word, output ready);
endinterface

interface lcs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lcs_pkg::LEVEL_W-1:0] brightness_level;

  modport source (output valid, brightness_level, input ready);
  modport sink (input valid, brightness_level, output ready);
endinterface

// ===== rtl/led_cube_layer_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// led_cube_layer_scanner_unit
// Frame store and time-multiplexed layer scan for a 4x4x4 LED cube.
// ---------------------------------------------------------------------------
// Each transaction on the input channel is either a store edit or read, or
// one microsecond tick, and yields exactly one result transaction. Every
// item is worked combinationally into a result register, so one item per
// clock is taken while the consumer keeps up; the result register is the
// only stage, and the next item is taken in the same cycle the held result
// leaves. The brightness register maps to a layer hold time through a
// 256-entry constant table at write time; writes are always taken.
module led_cube_layer_scanner_unit (
  input  logic  clk,
  input  logic  rst_n,
  lcs_in_if.sink     in_ch,
  lcs_out_if.source  out_ch,
  lcs_cfg_if.sink    cfg_ch
);

  lcs_pkg::lcs_cmd_t    cmd;
  lcs_pkg::lcs_result_t result;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cmd       (cmd)
  );

  lcs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .op        (in_ch.op),
    .x_pos     (in_ch.x_pos),
    .y_pos     (in_ch.y_pos),
    .layer_sel (in_ch.layer_sel),
    .pattern   (in_ch.pattern),
    .cfg_level (cfg_ch.brightness_level),
    .result    (result)
  );

  assign out_ch.layer_drive    = result.layer_drive;
  assign out_ch.column_word    = result.column_word;
  assign out_ch.layer_switched = result.layer_switched;
  assign out_ch.scan_complete  = result.scan_complete;
  assign out_ch.voxel_bit      = result.voxel_bit;
  assign out_ch.layer_word     = result.layer_word;

endmodule

// ===== rtl/lcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// lcs_ctrl
// Handshake controller: tracks whether the result register holds an
// undelivered result and issues load commands to the datapath.
// ---------------------------------------------------------------------------
module lcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output lcs_pkg::lcs_cmd_t cmd
);

  lcs_pkg::lcs_state_t state_r;
  lcs_pkg::lcs_state_t state_nxt;
  logic                load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcs_pkg::ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcs_pkg::ST_EMPTY: begin
        if (in_valid) begin
          state_nxt = lcs_pkg::ST_FULL;
        end
      end
      lcs_pkg::ST_FULL: begin
        // a new transaction can replace the one being taken
        if (out_ready && !in_valid) begin
          state_nxt = lcs_pkg::ST_EMPTY;
        end
      end
      default: state_nxt = lcs_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      lcs_pkg::ST_EMPTY: begin
        in_ready = 1'b1;
      end
      lcs_pkg::ST_FULL: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign load          = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign cmd.load_item = load;
  assign cmd.write_cfg = cfg_valid;

endmodule

// ===== rtl/lcs_datapath.sv =====
// ---------------------------------------------------------------------------
// lcs_datapath
// Frame store, scan counter and layer drive, hold-time register and the
// result register.
// ---------------------------------------------------------------------------
module lcs_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcs_pkg::lcs_cmd_t           cmd,
  input  logic [lcs_pkg::OP_W-1:0]    op,
  input  logic [lcs_pkg::COORD_W-1:0] x_pos,
  input  logic [lcs_pkg::COORD_W-1:0] y_pos,
  input  logic [lcs_pkg::COORD_W-1:0] layer_sel,
  input  logic [lcs_pkg::WORD_W-1:0]  pattern,
  input  logic [lcs_pkg::LEVEL_W-1:0] cfg_level,
  output lcs_pkg::lcs_result_t        result
);

  logic [lcs_pkg::WORD_W-1:0]  store_r   [lcs_pkg::LAYERS];
  logic [lcs_pkg::WORD_W-1:0]  store_nxt [lcs_pkg::LAYERS];
  logic [lcs_pkg::SCAN_W-1:0]  scan_r;
  logic [lcs_pkg::SCAN_W-1:0]  scan_nxt;
  lcs_pkg::lcs_hold_t          count_r;
  lcs_pkg::lcs_hold_t          count_nxt;
  lcs_pkg::lcs_hold_t          count_inc;
  lcs_pkg::lcs_hold_t          hold_r;
  logic [lcs_pkg::WORD_W-1:0]  latch_r;
  logic [lcs_pkg::WORD_W-1:0]  latch_nxt;
  logic [lcs_pkg::DRIVE_W-1:0] drive_r;
  logic [lcs_pkg::DRIVE_W-1:0] drive_nxt;
  lcs_pkg::lcs_result_t        result_r;
  lcs_pkg::lcs_result_t        result_nxt;

  lcs_pkg::lcs_op_t            op_code;
  logic                        is_tick;
  logic                        layer_ok;
  logic                        vox_ok;
  logic [lcs_pkg::POS_W-1:0]   pos;
  logic [lcs_pkg::SCAN_W-1:0]  rd_idx;
  logic [lcs_pkg::WORD_W-1:0]  rd_word;
  logic [lcs_pkg::WORD_W-1:0]  mask;
  logic [lcs_pkg::WORD_W-1:0]  word_new;
  logic [lcs_pkg::WORD_W-1:0]  word_out;
  logic                        step;

  assign op_code  = lcs_pkg::lcs_op_t'(op);
  assign is_tick  = (op_code == lcs_pkg::OP_TICK);
  assign pos      = lcs_pkg::POS_W'(int'(y_pos) * lcs_pkg::ROW_LEDS + int'(x_pos));
  assign layer_ok = int'(layer_sel) < lcs_pkg::LAYERS;
  assign vox_ok   = layer_ok && (int'(x_pos) < lcs_pkg::ROW_LEDS)
                    && (int'(y_pos) < lcs_pkg::ROWS) && (int'(pos) < lcs_pkg::WORD_W);

  // ticks read the layer being scanned, edits the addressed layer
  assign rd_idx  = is_tick ? scan_r : lcs_pkg::SCAN_W'(layer_sel);
  assign rd_word = store_r[rd_idx];
  assign mask    = vox_ok ? (lcs_pkg::WORD_W'(1) << pos[$clog2(lcs_pkg::WORD_W)-1:0]) : '0;

  assign count_inc = (count_r == lcs_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign step      = is_tick && (count_inc >= hold_r);

  always_comb begin
    store_nxt = store_r;
    scan_nxt  = scan_r;
    count_nxt = count_r;
    latch_nxt = latch_r;
    drive_nxt = drive_r;
    word_new  = rd_word;
    word_out  = '0;

    case (op_code)
      lcs_pkg::OP_SET:    word_new = rd_word | mask;
      lcs_pkg::OP_CLEAR:  word_new = rd_word & ~mask;
      lcs_pkg::OP_TOGGLE: word_new = rd_word ^ mask;
      lcs_pkg::OP_WRITE:  word_new = pattern;
      lcs_pkg::OP_FILL:   word_new = '1;
      lcs_pkg::OP_WIPE:   word_new = '0;
      default:            word_new = rd_word;
    endcase

    if (is_tick) begin
      count_nxt = count_inc;
      if (step) begin
        count_nxt = '0;
        latch_nxt = rd_word;
        for (int i = 0; i < lcs_pkg::DRIVE_W; i++) begin
          drive_nxt[i] = !(int'(scan_r) == i);
        end
        scan_nxt = (int'(scan_r) == lcs_pkg::LAYERS - 1) ? '0 : scan_r + 1'b1;
      end
    end else begin
      case (op_code)
        lcs_pkg::OP_FILL, lcs_pkg::OP_WIPE: begin
          for (int i = 0; i < lcs_pkg::LAYERS; i++) begin
            store_nxt[i] = word_new;
          end
        end
        default: begin
          if (layer_ok) begin
            store_nxt[rd_idx] = word_new;
          end
        end
      endcase
      word_out = layer_ok ? word_new : '0;
    end

    result_nxt.layer_drive    = drive_nxt;
    result_nxt.column_word    = latch_nxt;
    result_nxt.layer_switched = step;
    result_nxt.scan_complete  = step && (scan_nxt == '0);
    result_nxt.voxel_bit      = vox_ok && !is_tick
                                && word_out[pos[$clog2(lcs_pkg::WORD_W)-1:0]];
    result_nxt.layer_word     = word_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcs_pkg::LAYERS; i++) begin
        store_r[i] <= '0;
      end
      scan_r  <= '0;
      count_r <= '0;
      latch_r <= '0;
      drive_r <= '1;
      hold_r  <= lcs_pkg::HOLD_RESET;
    end else begin
      if (cmd.load_item) begin
        store_r <= store_nxt;
        scan_r  <= scan_nxt;
        count_r <= count_nxt;
        latch_r <= latch_nxt;
        drive_r <= drive_nxt;
      end
      if (cmd.write_cfg) begin
        hold_r <= lcs_pkg::HOLD_TABLE[cfg_level];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ===== tb/sv/led_cube_layer_scanner_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_cube_layer_scanner_unit_test
// Self-checking bench for the cube layer scanner. A queue-fed driver offers
// store edits, reads and ticks; a monitor predicts each accepted item with a
// local model of the frame store and scan, and compares every result
// transaction in order. Brightness changes happen between idle phases.
// ---------------------------------------------------------------------------
module led_cube_layer_scanner_unit_test;

  typedef struct packed {
    lcs_pkg::lcs_op_t             op;
    logic [lcs_pkg::COORD_W-1:0]  x_pos;
    logic [lcs_pkg::COORD_W-1:0]  y_pos;
    logic [lcs_pkg::COORD_W-1:0]  layer_sel;
    logic [lcs_pkg::WORD_W-1:0]   pattern;
  } cube_item_t;

  localparam int ITEMS_PER_PHASE = 600;
  localparam int ITEM_TARGET     = 1350;
  localparam int MAX_PHASES      = 60;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam logic [lcs_pkg::LEVEL_W-1:0] LEVEL_PLAN [10] =
    '{8'd255, 8'd10, 8'd0, 8'd128, 8'd9, 8'd11, 8'd254, 8'd77, 8'd200, 8'd3};

  logic clk;
  logic rst_n;

  lcs_in_if  in_ch();
  lcs_out_if out_ch();
  lcs_cfg_if cfg_ch();

  led_cube_layer_scanner_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the scanner state
  logic [lcs_pkg::WORD_W-1:0]  frame_mem [lcs_pkg::LAYERS];
  logic [lcs_pkg::SCAN_W-1:0]  scan_idx;
  logic [lcs_pkg::COUNT_W-1:0] dwell_count;
  logic [lcs_pkg::WORD_W-1:0]  col_latch;
  logic [lcs_pkg::DRIVE_W-1:0] drive_reg;
  logic [lcs_pkg::LEVEL_W-1:0] level_reg;

  cube_item_t           pending_items [$];
  lcs_pkg::lcs_result_t expected_results [$];

  logic in_took;
  logic rx_hold;
  logic rx_hold_req;
  int   send_gap_pct;
  int   recv_gap_pct;
  int   errors;
  int   items_queued;

  always #1 clk = ~clk;

  function automatic logic [lcs_pkg::LEVEL_W-1:0] clamp_level(
    logic [lcs_pkg::LEVEL_W-1:0] v);
    if (v < lcs_pkg::LEVEL_MIN) return lcs_pkg::LEVEL_W'(lcs_pkg::LEVEL_MIN);
    if (v > lcs_pkg::LEVEL_MAX) return lcs_pkg::LEVEL_W'(lcs_pkg::LEVEL_MAX);
    return v;
  endfunction

  function automatic int dwell_limit();
    if (lcs_pkg::LEVEL_MAX <= lcs_pkg::LEVEL_MIN) return lcs_pkg::HOLD_MAX_US;
    return lcs_pkg::HOLD_MIN_US + (int'(level_reg) - lcs_pkg::LEVEL_MIN)
           * (lcs_pkg::HOLD_MAX_US - lcs_pkg::HOLD_MIN_US)
           / (lcs_pkg::LEVEL_MAX - lcs_pkg::LEVEL_MIN);
  endfunction

  // advances the local state by one item and returns the result it causes
  function automatic lcs_pkg::lcs_result_t cube_scan_step(cube_item_t it);
    lcs_pkg::lcs_result_t       r;
    logic [3:0]                 pos;
    logic [lcs_pkg::WORD_W-1:0] m;
    r = '0;
    if (it.op == lcs_pkg::OP_TICK) begin
      if (dwell_count != lcs_pkg::COUNT_MAX) dwell_count = dwell_count + 1'b1;
      if (int'(dwell_count) >= dwell_limit()) begin
        dwell_count      = '0;
        col_latch        = frame_mem[scan_idx];
        drive_reg        = ~(lcs_pkg::DRIVE_W'(1) << scan_idx);
        scan_idx         = scan_idx + 1'b1;
        r.layer_switched = 1'b1;
        r.scan_complete  = (scan_idx == '0);
      end
    end else begin
      pos = {it.y_pos, it.x_pos};
      m   = lcs_pkg::WORD_W'(1) << pos;
      case (it.op)
        lcs_pkg::OP_SET:    frame_mem[it.layer_sel] = frame_mem[it.layer_sel] | m;
        lcs_pkg::OP_CLEAR:  frame_mem[it.layer_sel] = frame_mem[it.layer_sel] & ~m;
        lcs_pkg::OP_TOGGLE: frame_mem[it.layer_sel] = frame_mem[it.layer_sel] ^ m;
        lcs_pkg::OP_WRITE:  frame_mem[it.layer_sel] = it.pattern;
        lcs_pkg::OP_FILL: begin
          for (int i = 0; i < lcs_pkg::LAYERS; i++) frame_mem[i] = '1;
        end
        lcs_pkg::OP_WIPE: begin
          for (int i = 0; i < lcs_pkg::LAYERS; i++) frame_mem[i] = '0;
        end
        default: ;
      endcase
      r.layer_word = frame_mem[it.layer_sel];
      r.voxel_bit  = r.layer_word[pos];
    end
    r.layer_drive = drive_reg;
    r.column_word = col_latch;
    return r;
  endfunction

  task automatic check_field(string name, logic [lcs_pkg::WORD_W-1:0] want,
                             logic [lcs_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic void queue_item(lcs_pkg::lcs_op_t op, int x, int y, int z, int pat);
    cube_item_t it;
    it.op        = op;
    it.x_pos     = lcs_pkg::COORD_W'(x);
    it.y_pos     = lcs_pkg::COORD_W'(y);
    it.layer_sel = lcs_pkg::COORD_W'(z);
    it.pattern   = lcs_pkg::WORD_W'(pat);
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_random_item();
    lcs_pkg::lcs_op_t op;
    op = ($urandom_range(99) < 85) ? lcs_pkg::OP_TICK
                                   : lcs_pkg::lcs_op_t'($urandom_range(1, 7));
    queue_item(op, $urandom_range(3), $urandom_range(3), $urandom_range(3),
               $urandom_range(16'hFFFF));
  endfunction

  task automatic write_level(input logic [lcs_pkg::LEVEL_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid            = 1'b1;
    cfg_ch.brightness_level = v;
    do @(posedge clk); while (!cfg_ch.ready);
    level_reg = clamp_level(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // driver: holds an item until it is taken, then maybe picks the next one
  always @(negedge clk) begin : drive_items
    cube_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= nxt.op;
        in_ch.x_pos     <= nxt.x_pos;
        in_ch.y_pos     <= nxt.y_pos;
        in_ch.layer_sel <= nxt.layer_sel;
        in_ch.pattern   <= nxt.pattern;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    out_ch.ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_gap_pct);
  end

  // long receiver stall so the result register fills and input backs up
  initial begin : rx_stall
    rx_hold = 1'b0;
    while (rx_hold_req !== 1'b1) @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor: check results first, then predict the item taken this edge
  always @(posedge clk) begin : watch_results
    lcs_pkg::lcs_result_t want;
    cube_item_t           cur;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("layer_drive", lcs_pkg::WORD_W'(want.layer_drive),
                      lcs_pkg::WORD_W'(out_ch.layer_drive));
          check_field("column_word", want.column_word, out_ch.column_word);
          check_field("layer_switched", lcs_pkg::WORD_W'(want.layer_switched),
                      lcs_pkg::WORD_W'(out_ch.layer_switched));
          check_field("scan_complete", lcs_pkg::WORD_W'(want.scan_complete),
                      lcs_pkg::WORD_W'(out_ch.scan_complete));
          check_field("voxel_bit", lcs_pkg::WORD_W'(want.voxel_bit),
                      lcs_pkg::WORD_W'(out_ch.voxel_bit));
          check_field("layer_word", want.layer_word, out_ch.layer_word);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cur.op        = lcs_pkg::lcs_op_t'(in_ch.op);
        cur.x_pos     = in_ch.x_pos;
        cur.y_pos     = in_ch.y_pos;
        cur.layer_sel = in_ch.layer_sel;
        cur.pattern   = in_ch.pattern;
        want = cube_scan_step(cur);
        expected_results.push_back(want);
        in_took <= 1'b1;
      end else begin
        in_took <= 1'b0;
      end
    end
  end

  initial begin : time_limit
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int n_items;
    logic [lcs_pkg::LEVEL_W-1:0] lvl;
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.op                = lcs_pkg::OP_TICK;
    in_ch.x_pos             = '0;
    in_ch.y_pos             = '0;
    in_ch.layer_sel         = '0;
    in_ch.pattern           = '0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.brightness_level = '0;
    in_took                 = 1'b0;
    rx_hold_req             = 1'b0;
    send_gap_pct            = 18;
    recv_gap_pct            = 53;
    errors                  = 0;
    items_queued            = 0;
    for (int i = 0; i < lcs_pkg::LAYERS; i++) frame_mem[i] = '0;
    scan_idx    = '0;
    dwell_count = '0;
    col_latch   = '0;
    drive_reg   = '1;
    level_reg   = lcs_pkg::LEVEL_W'(lcs_pkg::LEVEL_MAX);

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: corners of the cube, every op, ticks carrying junk fields
    queue_item(lcs_pkg::OP_READ,   0, 0, 0, 0);
    queue_item(lcs_pkg::OP_SET,    0, 0, 0, 16'hFFFF);
    queue_item(lcs_pkg::OP_SET,    3, 3, 3, 0);
    queue_item(lcs_pkg::OP_TOGGLE, 1, 2, 1, 0);
    queue_item(lcs_pkg::OP_TOGGLE, 1, 2, 1, 0);
    queue_item(lcs_pkg::OP_CLEAR,  0, 0, 0, 0);
    queue_item(lcs_pkg::OP_WRITE,  0, 0, 2, 16'hFFFF);
    queue_item(lcs_pkg::OP_WRITE,  2, 1, 1, 16'hA5C3);
    queue_item(lcs_pkg::OP_READ,   3, 3, 1, 0);
    queue_item(lcs_pkg::OP_WRITE,  0, 0, 2, 16'h0000);
    queue_item(lcs_pkg::OP_FILL,   1, 1, 0, 0);
    queue_item(lcs_pkg::OP_CLEAR,  2, 1, 2, 0);
    queue_item(lcs_pkg::OP_READ,   3, 0, 3, 0);
    queue_item(lcs_pkg::OP_WIPE,   3, 3, 3, 16'hFFFF);
    queue_item(lcs_pkg::OP_READ,   2, 1, 2, 0);
    queue_item(lcs_pkg::OP_TICK,   3, 3, 3, 16'hFFFF);
    queue_item(lcs_pkg::OP_WRITE,  1, 3, 0, 16'h5A3C);
    queue_item(lcs_pkg::OP_TICK,   0, 0, 0, 0);
    queue_item(lcs_pkg::OP_SET,    3, 0, 0, 0);
    queue_item(lcs_pkg::OP_READ,   3, 0, 0, 0);
    wait_drained();

    // random phases; a lowered level after a long one lands past the new hold
    phase = 0;
    while (items_queued < ITEM_TARGET && phase < MAX_PHASES) begin
      case (phase % 3)
        0: begin
          send_gap_pct = 18;
          recv_gap_pct = 53;
        end
        1: begin
          send_gap_pct = 53;
          recv_gap_pct = 18;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      lvl = (phase < 10) ? LEVEL_PLAN[phase]
                         : lcs_pkg::LEVEL_W'($urandom_range(0, 40));
      write_level(lvl);
      n_items = ITEM_TARGET - items_queued;
      if (n_items > ITEMS_PER_PHASE) n_items = ITEMS_PER_PHASE;
      repeat (n_items) queue_random_item();
      if (phase == 1) rx_hold_req = 1'b1;
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
